@@ rtl/core/rmv_pkg.sv @@
package rmv_pkg;

	// sequencer states of the statistics engine
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_MEAN_DIV,
		ST_MUL_GO,
		ST_MUL,
		ST_STATS,
		ST_VAR_DIV,
		ST_SD_DIV,
		ST_EM_DIV,
		ST_EM_SQRT,
		ST_DONE
	} rmv_state_t;

	// status of one shared arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	localparam int DVD_BITS   = 64;
	localparam int DIV_STEPS  = 64;
	localparam int ROOT_BITS  = 32;
	localparam int ROOT_STEPS = 32;
	localparam int SUM_BITS   = 63;

	localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

endpackage

@@ rtl/core/rmv_div.sv @@
module rmv_div #(
	parameter int DSR_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [rmv_pkg::DVD_BITS-1:0]   dividend,
	input  logic [DSR_BITS-1:0]            divisor,
	output rmv_pkg::unit_stat_t            stat,
	output logic [rmv_pkg::DVD_BITS-1:0]   quotient
);
	import rmv_pkg::*;

	localparam int CNT_BITS = $clog2(DIV_STEPS);

	logic [DVD_BITS-1:0] dvd_q;
	logic [DSR_BITS-1:0] dsr_q;
	logic [DSR_BITS-1:0] rem_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [DSR_BITS:0]   trial;
	logic [DSR_BITS:0]   diff;
	logic                ge;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, dvd_q[DVD_BITS-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DSR_BITS-1:0] : trial[DSR_BITS-1:0];
			dvd_q <= {dvd_q[DVD_BITS-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;

endmodule

@@ rtl/core/rmv_sqrt.sv @@
module rmv_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rmv_pkg::DVD_BITS-1:0]  radicand,
	output rmv_pkg::unit_stat_t           stat,
	output logic [rmv_pkg::ROOT_BITS-1:0] root
);
	import rmv_pkg::*;

	localparam int CNT_BITS = $clog2(ROOT_STEPS);
	localparam int REM_BITS = ROOT_BITS + 3;

	logic [DVD_BITS-1:0]  v_q;
	logic [REM_BITS-1:0]  rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [REM_BITS-1:0]  rem2;
	logic [REM_BITS-1:0]  trial;
	logic                 ge;

	// digit-by-digit root, two radicand bits a cycle
	assign rem2  = {rem_q[REM_BITS-3:0], v_q[DVD_BITS-1:DVD_BITS-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = rem2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(ROOT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? rem2 - trial : rem2;
			root_q <= {root_q[ROOT_BITS-2:0], ge};
			v_q    <= {v_q[DVD_BITS-3:0], 2'b00};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = root_q;

endmodule

@@ rtl/core/rmv_mul.sv @@
module rmv_mul #(
	parameter int OP_BITS = 48
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [OP_BITS-1:0]     op_a,
	input  logic [OP_BITS-1:0]     op_b,
	output rmv_pkg::unit_stat_t    stat,
	output logic [2*OP_BITS-1:0]   product
);
	import rmv_pkg::*;

	localparam int CNT_BITS = $clog2(OP_BITS);

	logic [OP_BITS-1:0]   a_q;
	logic [2*OP_BITS-1:0] p_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [OP_BITS:0]     acc;

	// shift-add, one multiplier bit a cycle
	assign acc = {1'b0, p_q[2*OP_BITS-1:OP_BITS]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(OP_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= op_a;
			p_q <= {{OP_BITS{1'b0}}, op_b};
		end else if (busy_q) begin
			p_q <= {acc, p_q[OP_BITS-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = p_q;

endmodule

@@ rtl/core/running_mean_variance.sv @@
// channel | direction | handshake              | payload
// input   | in        | in_valid / in_ready    | action, sample
// result  | out       | out_valid / out_ready  | sample_count .. dropped
//
// one item at a time; in_ready is high only while the sequencer is idle
// a push onto a non-empty set runs, in order: mean step division, shift-add product,
// S/N, S/(N-1), then q/N beside the root of S/(N-1), and last the root of q/N
// the shared 64-step divider is used four times (mean step, S/N, S/(N-1), q/N)
// a clear jumps to the final state, a dropped push skips the mean and sum updates
// a finished result waits in the output register; the next item is taken meanwhile
// asynchronous active-low reset zeroes all statistics, no clearing pass
module running_mean_variance #(
	parameter int COUNT_BITS      = 24,
	parameter int SAMPLE_BITS     = 32,
	parameter int EXTRA_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic signed [31:0] sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [23:0]        sample_count,
	output logic signed [31:0] running_mean,
	output logic [62:0]        squared_dev_sum,
	output logic [62:0]        population_variance,
	output logic [31:0]        sample_deviation,
	output logic [31:0]        error_of_mean,
	output logic signed [31:0] smallest_value,
	output logic signed [31:0] largest_value,
	output logic               mean_ok,
	output logic               spread_ok,
	output logic               dropped
);
	import rmv_pkg::*;

	localparam int SB  = SAMPLE_BITS;
	localparam int EFB = EXTRA_FRAC_BITS;
	localparam int MW  = SB + EFB;          // internal mean width
	localparam int PW  = 2 * MW;            // full product width
	localparam int HALF = (EFB > 0) ? (1 << (EFB - 1)) : 0;
	localparam logic [COUNT_BITS-1:0] COUNT_FULL = {COUNT_BITS{1'b1}};

	rmv_state_t state_q, state_d;

	// statistics state
	logic [COUNT_BITS-1:0] count_q;
	logic signed [MW-1:0]  mean_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic signed [SB-1:0]  min_q;
	logic signed [SB-1:0]  max_q;

	// per-item working registers
	logic                  action_q;
	logic signed [SB-1:0]  x_q;
	logic signed [MW:0]    del_q;
	logic                  drop_q;
	logic [SUM_BITS-1:0]   pvar_q;
	logic [ROOT_BITS-1:0]  sd_q;
	logic [ROOT_BITS-1:0]  em_q;
	logic                  out_valid_q;

	// shared units
	logic                  div_start;
	logic [DVD_BITS-1:0]   div_dvd;
	logic [COUNT_BITS-1:0] div_dsr;
	logic [DVD_BITS-1:0]   div_quo;
	unit_stat_t            div_stat;
	logic                  sqrt_start;
	logic [DVD_BITS-1:0]   sqrt_arg;
	logic [ROOT_BITS-1:0]  sqrt_root;
	unit_stat_t            sqrt_stat;
	logic                  mul_start;
	logic [PW-1:0]         mul_prod;
	unit_stat_t            mul_stat;

	// datapath helpers
	logic signed [MW-1:0]  xs;
	logic signed [MW:0]    del_now;
	logic [MW-1:0]         del_mag_now;
	logic [MW-1:0]         del_mag;
	logic signed [MW:0]    diff2;
	logic [MW-1:0]         diff2_mag;
	logic [COUNT_BITS-1:0] count_inc;
	logic [DVD_BITS-1:0]   prod_sh;
	logic [SUM_BITS-1:0]   prod_sat;
	logic [SUM_BITS:0]     sum_new;
	logic signed [MW:0]    mean_round;
	logic                  accept;
	logic                  out_free;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// sample scaled into the internal mean format
	assign xs          = MW'(x_q) <<< EFB;
	assign del_now     = {xs[MW-1], xs} - {mean_q[MW-1], mean_q};
	assign del_mag_now = del_now[MW] ? MW'(-del_now) : del_now[MW-1:0];
	assign del_mag     = del_q[MW] ? MW'(-del_q) : del_q[MW-1:0];
	// second Welford factor uses the already updated mean
	assign diff2       = {xs[MW-1], xs} - {mean_q[MW-1], mean_q};
	assign diff2_mag   = diff2[MW] ? MW'(-diff2) : diff2[MW-1:0];
	assign count_inc   = count_q + 1'b1;

	// product back to an unsigned integer (Q63.0), saturating
	assign prod_sh  = DVD_BITS'(mul_prod >> (2 * EFB));
	assign prod_sat = prod_sh[DVD_BITS-1] ? SUM_MAX : prod_sh[SUM_BITS-1:0];
	assign sum_new  = {1'b0, sum_q} + {1'b0, prod_sat};

	// round half up to a signed integer (Q32.0)
	assign mean_round = ({mean_q[MW-1], mean_q} + (MW + 1)'(HALF)) >>> EFB;

	rmv_div #(
		.DSR_BITS (COUNT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	rmv_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sqrt_arg),
		.stat     (sqrt_stat),
		.root     (sqrt_root)
	);

	rmv_mul #(
		.OP_BITS (MW)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.op_a    (del_mag),
		.op_b    (diff2_mag),
		.stat    (mul_stat),
		.product (mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and unit launches
	always_comb begin
		state_d    = state_q;
		div_start  = 1'b0;
		div_dvd    = DVD_BITS'(del_mag_now);
		div_dsr    = count_inc;
		sqrt_start = 1'b0;
		sqrt_arg   = div_quo;
		mul_start  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (action_q || count_q == COUNT_FULL || count_q == '0) begin
					state_d = action_q ? ST_DONE : ST_STATS;
				end else begin
					// mean step: |del| / N with N already incremented
					div_start = 1'b1;
					state_d   = ST_MEAN_DIV;
				end
			end
			ST_MEAN_DIV: begin
				if (div_stat.done) begin
					state_d = ST_MUL_GO;
				end
			end
			ST_MUL_GO: begin
				mul_start = 1'b1;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				if (mul_stat.done) begin
					state_d = ST_STATS;
				end
			end
			ST_STATS: begin
				if (count_q != '0) begin
					div_start = 1'b1;
					div_dvd   = DVD_BITS'(sum_q);
					div_dsr   = count_q;
					state_d   = ST_VAR_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_VAR_DIV: begin
				if (div_stat.done) begin
					if (count_q > COUNT_BITS'(1)) begin
						div_start = 1'b1;
						div_dvd   = DVD_BITS'(sum_q);
						div_dsr   = count_q - 1'b1;
						state_d   = ST_SD_DIV;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SD_DIV: begin
				if (div_stat.done) begin
					// root of S/(N-1) and (S/(N-1))/N run side by side
					sqrt_start = 1'b1;
					div_start  = 1'b1;
					div_dvd    = div_quo;
					div_dsr    = count_q;
					state_d    = ST_EM_DIV;
				end
			end
			ST_EM_DIV: begin
				if (div_stat.done) begin
					sqrt_start = 1'b1;
					state_d    = ST_EM_SQRT;
				end
			end
			ST_EM_SQRT: begin
				if (sqrt_stat.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	// statistics registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mean_q  <= '0;
			sum_q   <= '0;
			min_q   <= '0;
			max_q   <= '0;
		end else begin
			if (state_q == ST_UPDATE) begin
				if (action_q) begin
					count_q <= '0;
					mean_q  <= '0;
					sum_q   <= '0;
				end else if (count_q != COUNT_FULL) begin
					count_q <= count_inc;
					if (count_q == '0) begin
						// first sample after a clear
						mean_q <= xs;
						min_q  <= x_q;
						max_q  <= x_q;
					end
				end
			end
			if (state_q == ST_MEAN_DIV && div_stat.done) begin
				mean_q <= del_q[MW] ? mean_q - MW'(div_quo) : mean_q + MW'(div_quo);
			end
			if (state_q == ST_MUL && mul_stat.done) begin
				sum_q <= sum_new[SUM_BITS] ? SUM_MAX : sum_new[SUM_BITS-1:0];
				if (x_q < min_q) begin
					min_q <= x_q;
				end
				if (x_q > max_q) begin
					max_q <= x_q;
				end
			end
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			x_q      <= sample[SB-1:0];
		end
		if (state_q == ST_UPDATE) begin
			del_q  <= del_now;
			drop_q <= !action_q && count_q == COUNT_FULL;
		end
		if (state_q == ST_VAR_DIV && div_stat.done) begin
			pvar_q <= div_quo[SUM_BITS-1:0];
		end
		if (state_q == ST_EM_DIV && sqrt_stat.done) begin
			sd_q <= sqrt_root;
		end
		if (state_q == ST_EM_SQRT && sqrt_stat.done) begin
			em_q <= sqrt_root;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			sample_count        <= 24'(count_q);
			squared_dev_sum     <= sum_q;
			mean_ok             <= count_q != '0;
			spread_ok           <= count_q > COUNT_BITS'(1);
			dropped             <= drop_q;
			if (count_q != '0) begin
				running_mean        <= 32'(mean_round);
				population_variance <= pvar_q;
				smallest_value      <= 32'(min_q);
				largest_value       <= 32'(max_q);
			end else begin
				running_mean        <= '0;
				population_variance <= '0;
				smallest_value      <= '0;
				largest_value       <= '0;
			end
			if (count_q > COUNT_BITS'(1)) begin
				sample_deviation <= sd_q;
				error_of_mean    <= em_q;
			end else begin
				sample_deviation <= '0;
				error_of_mean    <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// neither the divider nor the root unit is relaunched mid-operation
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider launched while busy");

	a_sqrt_free: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_start |-> !sqrt_stat.busy)
		else $error("root unit launched while busy");

	// input transfer only with all units quiet
	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !div_stat.busy && !sqrt_stat.busy && !mul_stat.busy)
		else $error("input taken while arithmetic busy");

	// a result appears only out of the final state
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside final state");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && spread_ok |-> mean_ok)
		else $error("spread flag without mean flag");

endmodule

@@ test/running_mean_variance_tb.sv @@
`timescale 1ns / 100ps

module running_mean_variance_tb;

	localparam int        HALF_PERIOD = 4;
	localparam int        IDLE_LIMIT  = 20000;
	localparam int        HOLD_CYCLES = 2000;
	localparam bit        ACT_PUSH    = 1'b0;
	localparam bit        ACT_CLEAR   = 1'b1;
	localparam logic [62:0] SUM_CAP   = {63{1'b1}};
	localparam longint unsigned FULL_COUNT = 64'hFF_FFFF;

	// one result transfer, field per port
	typedef struct {
		logic [23:0]        cnt;
		logic signed [31:0] mean;
		logic [62:0]        dev_sum;
		logic [62:0]        pop_var;
		logic [31:0]        deviation;
		logic [31:0]        err_mean;
		logic signed [31:0] lo_val;
		logic signed [31:0] hi_val;
		logic               m_ok;
		logic               s_ok;
		logic               drop;
	} stats_t;

	// welford statistics predictor with its own copy of the running state
	class stats_predictor;
		longint unsigned n;
		longint          mean_fine;
		longint unsigned dev_sum;
		longint          lo_seen;
		longint          hi_seen;
		stats_t          expected_stats[$];
		int              errors;
		int              pushes;
		int              clears;
		int              saturated;

		function void wipe();
			n = 0; mean_fine = 0; dev_sum = 0; lo_seen = 0; hi_seen = 0;
			errors = 0; pushes = 0; clears = 0; saturated = 0;
		endfunction

		function longint unsigned root64(longint unsigned v);
			longint unsigned res;
			longint unsigned probe;
			res = 0;
			probe = 64'd1 << 62;
			while (probe > v)
				probe >>= 2;
			while (probe != 0) begin
				if (v >= res + probe) begin
					v -= res + probe;
					res = (res >> 1) + probe;
				end else begin
					res >>= 1;
				end
				probe >>= 2;
			end
			return res;
		endfunction

		function void note_item(bit act, logic signed [31:0] smp);
			stats_t          e;
			longint          x, xs, del, del2;
			longint unsigned step, q;
			logic [127:0]    prod;
			logic [63:0]     sum;
			bit              drop;
			drop = 0;
			x = smp;
			xs = x <<< 16;
			if (act == ACT_CLEAR) begin
				n = 0; mean_fine = 0; dev_sum = 0;
				clears++;
			end else if (n >= FULL_COUNT) begin
				drop = 1;
			end else begin
				pushes++;
				n++;
				if (n == 1) begin
					mean_fine = xs; lo_seen = x; hi_seen = x;
				end else begin
					del = xs - mean_fine;
					step = (del < 0 ? -del : del) / n;
					mean_fine = del < 0 ? mean_fine - longint'(step)
						: mean_fine + longint'(step);
					del2 = xs - mean_fine;
					prod = 128'(del < 0 ? -del : del) * 128'(del2 < 0 ? -del2 : del2);
					prod = prod >> 32;
					if (prod > 128'(SUM_CAP))
						prod = 128'(SUM_CAP);
					sum = dev_sum + prod[63:0];
					dev_sum = sum > 64'(SUM_CAP) ? 64'(SUM_CAP) : sum;
					if (x < lo_seen) lo_seen = x;
					if (x > hi_seen) hi_seen = x;
				end
			end
			if (dev_sum == 64'(SUM_CAP))
				saturated++;
			e.cnt = n[23:0];
			e.dev_sum = dev_sum[62:0];
			e.m_ok = n >= 1;
			e.s_ok = n >= 2;
			e.drop = drop;
			if (n >= 1) begin
				e.mean = 32'((mean_fine + 64'sd32768) >>> 16);
				e.pop_var = 63'(dev_sum / n);
				e.lo_val = lo_seen[31:0];
				e.hi_val = hi_seen[31:0];
			end else begin
				e.mean = 0; e.pop_var = 0; e.lo_val = 0; e.hi_val = 0;
			end
			if (n >= 2) begin
				q = dev_sum / (n - 1);
				e.deviation = 32'(root64(q));
				e.err_mean = 32'(root64(q / n));
			end else begin
				e.deviation = 0; e.err_mean = 0;
			end
			expected_stats.push_back(e);
		endfunction

		function void field(string name, logic [63:0] exp_v, logic [63:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t mismatch %s: expected %h, actual %h", $time, name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_stats(stats_t a);
			stats_t e;
			if (expected_stats.size() == 0) begin
				$display("%0t unexpected result transfer, count %0d", $time, a.cnt);
				errors++;
				return;
			end
			e = expected_stats.pop_front();
			field("sample_count", e.cnt, a.cnt);
			field("running_mean", e.mean, a.mean);
			field("squared_dev_sum", e.dev_sum, a.dev_sum);
			field("population_variance", e.pop_var, a.pop_var);
			field("sample_deviation", e.deviation, a.deviation);
			field("error_of_mean", e.err_mean, a.err_mean);
			field("smallest_value", e.lo_val, a.lo_val);
			field("largest_value", e.hi_val, a.hi_val);
			field("mean_ok", e.m_ok, a.m_ok);
			field("spread_ok", e.s_ok, a.s_ok);
			field("dropped", e.drop, a.drop);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               action;
	logic signed [31:0] sample;
	logic               out_valid;
	logic               out_ready;
	logic [23:0]        sample_count;
	logic signed [31:0] running_mean;
	logic [62:0]        squared_dev_sum;
	logic [62:0]        population_variance;
	logic [31:0]        sample_deviation;
	logic [31:0]        error_of_mean;
	logic signed [31:0] smallest_value;
	logic signed [31:0] largest_value;
	logic               mean_ok;
	logic               spread_ok;
	logic               dropped;

	stats_predictor stats = new();
	bit             hold_req;
	int             idle_cycles;

	running_mean_variance uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.sample_count(sample_count), .running_mean(running_mean),
		.squared_dev_sum(squared_dev_sum), .population_variance(population_variance),
		.sample_deviation(sample_deviation), .error_of_mean(error_of_mean),
		.smallest_value(smallest_value), .largest_value(largest_value),
		.mean_ok(mean_ok), .spread_ok(spread_ok), .dropped(dropped)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// result side: every accepted result goes to the predictor's check
	always @(posedge clk) begin
		stats_t got;
		if (arst_n && out_valid && out_ready) begin
			got.cnt = sample_count;
			got.mean = running_mean;
			got.dev_sum = squared_dev_sum;
			got.pop_var = population_variance;
			got.deviation = sample_deviation;
			got.err_mean = error_of_mean;
			got.lo_val = smallest_value;
			got.hi_val = largest_value;
			got.m_ok = mean_ok;
			got.s_ok = spread_ok;
			got.drop = dropped;
			stats.check_stats(got);
		end
	end

	// watchdog: too long without any transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// receiver: stall style is redrawn at random whenever its phase runs out, with one long
	// hold-off on request so the output register fills and the input backs up
	initial begin
		int phase;
		int style;
		bit held;
		out_ready = 1'b0;
		phase = 0;
		style = 0;
		held = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				held = 1;
			end
			if (phase == 0) begin
				style = $urandom_range(0, 3);
				phase = $urandom_range(50, 300);
			end
			phase--;
			case (style)
				0: out_ready = 1'b1;
				1: out_ready = $urandom_range(0, 1);
				2: out_ready = ($urandom_range(0, 3) == 0);
				default: out_ready = ((phase % 16) < 5);
			endcase
		end
	end

	// one input transfer; inputs move on the falling edge only
	task automatic send_item(bit act, logic signed [31:0] smp);
		@(negedge clk);
		in_valid = 1'b1;
		action = act;
		sample = smp;
		do
			@(posedge clk);
		while (!in_ready);
		stats.note_item(act, smp);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		while (stats.expected_stats.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6:    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
			7:          return $signed($urandom_range(0, 64)) - 32'sd32;
			8:          return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default:    return 32'sh0003_0000 + ($signed($urandom_range(0, 511)) - 256);
		endcase
	endfunction

	initial begin
		int sent;
		int burst;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_PUSH;
		sample = 0;
		hold_req = 0;
		stats.wipe();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty clear, extremes, single sample, saturation, hidden extremes
		send_item(ACT_CLEAR, 0);
		send_item(ACT_PUSH, 32'sh7FFF_FFFF);
		send_item(ACT_PUSH, 32'sh8000_0000);
		send_item(ACT_PUSH, 0);
		send_item(ACT_PUSH, -1);
		send_item(ACT_PUSH, 1);
		send_item(ACT_CLEAR, 32'sh1234_5678);
		send_item(ACT_PUSH, 32'sh0001_0000);
		send_item(ACT_PUSH, 32'sh0001_0000);
		send_item(ACT_PUSH, 32'sh0001_8000);
		send_item(ACT_CLEAR, 0);
		for (int i = 0; i < 8; i++) begin
			// alternating full-scale values push the sum to its ceiling
			send_item(ACT_PUSH, 32'sh8000_0000);
			send_item(ACT_PUSH, 32'sh7FFF_FFFF);
		end
		send_item(ACT_CLEAR, 0);
		send_item(ACT_PUSH, -32'sd5);
		drain();

		// long receiver hold-off while the sender keeps offering
		hold_req = 1;
		for (int i = 0; i < 6; i++)
			send_item(ACT_PUSH, pick_sample());

		// random part in bursts; mostly pushes, with occasional clears
		sent = 0;
		while (sent < 1120) begin
			burst = $urandom_range(1, 25);
			for (int i = 0; i < burst; i++) begin
				if ($urandom_range(0, 39) == 0)
					send_item(ACT_CLEAR, $urandom);
				else
					send_item(ACT_PUSH, pick_sample());
				sent++;
			end
			if ($urandom_range(0, 30) == 0)
				drain();
			else if ($urandom_range(0, 2) != 0)
				repeat ($urandom_range(1, 40)) @(negedge clk);
		end

		drain();
		repeat (400) @(posedge clk);
		$display("covered %0d pushes and %0d clears; %0d results at the sum ceiling",
			stats.pushes, stats.clears, stats.saturated);
		if (stats.errors == 0 && stats.expected_stats.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d results missing", stats.errors,
				stats.expected_stats.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
